/* rtl/lc3b_instruction_executor_core_macros.svh */
// ----------------------------------------------------------------------------
// lc3b core assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LC3B_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define LC3B_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// same-cycle implication
`define LC3B_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LC3B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lc3b_pkg.sv */
// ----------------------------------------------------------------------------
// lc3b package
// request codes, opcodes, condition codes and shared types of the lc3b core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lc3b_pkg;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EXEC    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LDB  = 4'd2;
  localparam logic [3:0] OPC_STB  = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDW  = 4'd6;
  localparam logic [3:0] OPC_STW  = 4'd7;
  localparam logic [3:0] OPC_XOR  = 4'd9;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_SHF  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_BYTE = 2'd1;
  localparam logic [1:0] SK_WORD = 2'd2;

  localparam logic [2:0] CC_N = 3'd4;
  localparam logic [2:0] CC_Z = 3'd2;
  localparam logic [2:0] CC_P = 3'd1;

  localparam logic [2:0] REG_LINK = 3'd7;

  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [15:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic [1:0]  store_kind;
    logic [15:0] store_address;
    logic [15:0] store_value;
  } side_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  cond_codes;
    side_t       side;
    logic        halted;
  } rsp_t;

  function automatic logic [2:0] codes_of(input logic [15:0] v);
    if (v == 16'h0000) return CC_Z;
    return v[15] ? CC_N : CC_P;
  endfunction

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

endpackage

/* rtl/lc3b_if.sv */
// ----------------------------------------------------------------------------
// lc3b channel interfaces
// valid/ready channels for requests, results and the start pc register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lc3b_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [14:0] word_address;
  logic [15:0] write_data;
  modport source (output valid, op, word_address, write_data, input ready);
  modport sink (input valid, op, word_address, write_data, output ready);
endinterface

interface lc3b_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [2:0]  cond_codes;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic [1:0]  store_kind;
  logic [15:0] store_address;
  logic [15:0] store_value;
  logic        halted;
  modport source (output valid, next_pc, cond_codes, reg_written, reg_index, reg_value,
                  store_kind, store_address, store_value, halted, input ready);
  modport sink (input valid, next_pc, cond_codes, reg_written, reg_index, reg_value,
                store_kind, store_address, store_value, halted, output ready);
endinterface

interface lc3b_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/lc3b_mem.sv */
// ----------------------------------------------------------------------------
// lc3b word memory
// single port synchronous word memory with a zero fill sweep after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc3b_mem #(
  parameter int MEM_WORDS = 32768,
  parameter int AW        = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o,
  output logic          clr_busy_o
);

  logic [15:0]   mem_q [MEM_WORDS];
  logic [15:0]   rdata_q;
  logic [AW-1:0] clr_cnt_q;
  logic          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

/* rtl/lc3b_regs.sv */
// ----------------------------------------------------------------------------
// lc3b register file
// eight 16-bit registers, two registered read ports, one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc3b_regs
  import lc3b_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        re_i,
  input  logic [2:0]  ra_i,
  input  logic [2:0]  rb_i,
  input  rf_wr_t      wr_i,
  output logic [15:0] a_o,
  output logic [15:0] b_o
);

  logic [15:0] regs_q [8];
  logic [7:0]  valid_q;
  logic [15:0] a_q;
  logic [15:0] b_q;

  // unwritten registers read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      regs_q[wr_i.idx] <= wr_i.data;
    end
    if (re_i) begin
      a_q <= valid_q[ra_i] ? regs_q[ra_i] : 16'h0000;
      b_q <= valid_q[rb_i] ? regs_q[rb_i] : 16'h0000;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

/* rtl/lc3b_instruction_executor_core.sv */
// ----------------------------------------------------------------------------
// lc3b instruction executor core
// one-instruction-per-request lc3b core around a word memory and register file
// ----------------------------------------------------------------------------
// After reset the core sweeps zeros through all MEM_WORDS memory words, one
// word a cycle, and takes no request while the sweep runs (the start pc
// register can be written at any time). A memory write, restart, halted or
// unknown request goes from its transfer to the write back state, which loads
// the result register once the output slot is free; the next request is taken
// after that. An execute request passes fetch, register read, execute and
// write back, with a memory state between execute and write back for LDB,
// LDW, STB and TRAP, which need a second pass through the single memory port;
// STB is a read-modify-write of its word. One request is in the core at a
// time; a finished result waits in the output register.
`timescale 1ns / 1ps
`include "lc3b_instruction_executor_core_macros.svh"

module lc3b_instruction_executor_core
  import lc3b_pkg::*;
#(
  parameter int MEM_WORDS = 32768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lc3b_cfg_if.sink       cfg_i,
  lc3b_req_if.sink       req_i,
  lc3b_rsp_if.source     rsp_o
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IR   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  // word index modulo MEM_WORDS, by conditional subtraction of scaled modulus
  function automatic logic [AW-1:0] wrap(input logic [14:0] v);
    logic [22:0] r;
    r = {8'h00, v};
    for (int k = 6; k >= 0; k--) begin
      if (r >= (23'(MEM_WORDS) << k)) r = r - (23'(MEM_WORDS) << k);
    end
    return r[AW-1:0];
  endfunction

  logic [2:0]    state_q, state_d;
  logic [15:0]   pc_q, pc_d;
  logic [2:0]    cc_q, cc_d;
  logic [15:0]   start_pc_q;
  logic [15:0]   ir_q, ir_d;
  side_t         side_q, side_d;
  logic [AW-1:0] ea_q, ea_d;
  logic          ea_lsb_q, ea_lsb_d;
  rsp_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          mem_en, mem_we, clr_busy;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          rf_re;
  logic [2:0]    rf_ra, rf_rb;
  rf_wr_t        rf_wr;
  logic [15:0]   rf_a, rf_b;

  logic          req_fire, slot_free;
  logic [3:0]    opc, rd_opc;
  logic [2:0]    dr;
  logic [15:0]   inc, opnd_b, base6, word6, off6, off9, off11, br_tgt, jsr_tgt;
  logic [15:0]   alu_res, shf_res, ld_val;

  lc3b_mem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (mem_en),
    .we_i      (mem_we),
    .addr_i    (mem_addr),
    .wdata_i   (mem_wdata),
    .rdata_o   (mem_rdata),
    .clr_busy_o(clr_busy)
  );

  lc3b_regs u_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .re_i  (rf_re),
    .ra_i  (rf_ra),
    .rb_i  (rf_rb),
    .wr_i  (rf_wr),
    .a_o   (rf_a),
    .b_o   (rf_b)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  // register read addresses come straight from the fetched word
  assign rd_opc = mem_rdata[15:12];
  assign rf_re  = (state_q == S_IR);
  assign rf_ra  = mem_rdata[8:6];
  assign rf_rb  = (rd_opc == OPC_STB || rd_opc == OPC_STW) ? mem_rdata[11:9] : mem_rdata[2:0];

  assign opc     = ir_q[15:12];
  assign dr      = ir_q[11:9];
  assign inc     = pc_q + 16'd2;
  assign opnd_b  = ir_q[5] ? sext5(ir_q[4:0]) : rf_b;
  assign off6    = sext6(ir_q[5:0]);
  assign off9    = sext9(ir_q[8:0]);
  assign off11   = sext11(ir_q[10:0]);
  assign base6   = rf_a + off6;
  assign word6   = rf_a + {off6[14:0], 1'b0};
  assign br_tgt  = inc + {off9[14:0], 1'b0};
  assign jsr_tgt = ir_q[11] ? (inc + {off11[14:0], 1'b0}) : rf_a;
  assign ld_val  = ea_lsb_q ? sext8(mem_rdata[15:8]) : sext8(mem_rdata[7:0]);

  always_comb begin
    if (opc == OPC_ADD) begin
      alu_res = rf_a + opnd_b;
    end else if (opc == OPC_AND) begin
      alu_res = rf_a & opnd_b;
    end else begin
      alu_res = rf_a ^ opnd_b;
    end
  end

  always_comb begin
    if (!ir_q[4]) begin
      shf_res = rf_a << ir_q[3:0];
    end else if (!ir_q[5]) begin
      shf_res = rf_a >> ir_q[3:0];
    end else begin
      shf_res = 16'($signed(rf_a) >>> ir_q[3:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cc_d        = cc_q;
    ir_d        = ir_q;
    side_d      = side_q;
    ea_d        = ea_q;
    ea_lsb_d    = ea_lsb_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = '0;
    rf_wr       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          side_d  = '0;
          state_d = S_WB;
          if (req_i.op == OP_WRITE) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = wrap(req_i.word_address);
            mem_wdata = req_i.write_data;
          end else if (req_i.op == OP_RESTART) begin
            pc_d = start_pc_q;
            cc_d = CC_Z;
          end else if (req_i.op == OP_EXEC && pc_q != 16'h0000) begin
            mem_en   = 1'b1;
            mem_addr = wrap(pc_q[15:1]);
            state_d  = S_IR;
          end
        end
      end
      S_IR: begin
        ir_d    = mem_rdata;
        state_d = S_EX;
      end
      S_EX: begin
        state_d = S_WB;
        pc_d    = inc;
        case (opc)
          OPC_BR: begin
            if ((dr & cc_q) != 3'd0) pc_d = br_tgt;
          end
          OPC_ADD, OPC_AND, OPC_XOR: begin
            rf_wr = '{we: 1'b1, idx: dr, data: alu_res};
            cc_d  = codes_of(alu_res);
          end
          OPC_SHF: begin
            rf_wr = '{we: 1'b1, idx: dr, data: shf_res};
            cc_d  = codes_of(shf_res);
          end
          OPC_LEA: begin
            rf_wr = '{we: 1'b1, idx: dr, data: br_tgt};
          end
          OPC_JSR: begin
            pc_d  = jsr_tgt;
            rf_wr = '{we: 1'b1, idx: REG_LINK, data: inc};
          end
          OPC_JMP: begin
            pc_d = rf_a;
          end
          OPC_LDB: begin
            mem_en   = 1'b1;
            mem_addr = wrap(base6[15:1]);
            ea_lsb_d = base6[0];
            state_d  = S_MEM;
          end
          OPC_LDW: begin
            mem_en   = 1'b1;
            mem_addr = wrap(word6[15:1]);
            state_d  = S_MEM;
          end
          OPC_STB: begin
            mem_en               = 1'b1;
            mem_addr             = wrap(base6[15:1]);
            ea_d                 = wrap(base6[15:1]);
            ea_lsb_d             = base6[0];
            side_d.store_kind    = SK_BYTE;
            side_d.store_address = base6;
            side_d.store_value   = {8'h00, rf_b[7:0]};
            state_d              = S_MEM;
          end
          OPC_STW: begin
            mem_en               = 1'b1;
            mem_we               = 1'b1;
            mem_addr             = wrap(word6[15:1]);
            mem_wdata            = rf_b;
            side_d.store_kind    = SK_WORD;
            side_d.store_address = word6;
            side_d.store_value   = rf_b;
          end
          OPC_TRAP: begin
            mem_en   = 1'b1;
            mem_addr = AW'(ir_q[7:0]);
            rf_wr    = '{we: 1'b1, idx: REG_LINK, data: inc};
            state_d  = S_MEM;
          end
          default: begin
            // rti and the two unused opcodes leave everything alone
            pc_d = pc_q;
          end
        endcase
      end
      S_MEM: begin
        state_d = S_WB;
        case (opc)
          OPC_LDB: begin
            rf_wr = '{we: 1'b1, idx: dr, data: ld_val};
            cc_d  = codes_of(ld_val);
          end
          OPC_LDW: begin
            rf_wr = '{we: 1'b1, idx: dr, data: mem_rdata};
            cc_d  = codes_of(mem_rdata);
          end
          OPC_TRAP: begin
            pc_d = mem_rdata;
          end
          OPC_STB: begin
            // merge the byte into the word just read
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = ea_q;
            mem_wdata = ea_lsb_q ? {side_q.store_value[7:0], mem_rdata[7:0]}
                                 : {mem_rdata[15:8], side_q.store_value[7:0]};
          end
          default: begin
          end
        endcase
      end
      S_WB: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.next_pc    = pc_q;
          out_d.cond_codes = cc_q;
          out_d.side       = side_q;
          out_d.halted     = (pc_q == 16'h0000);
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rf_wr.we) begin
      side_d.reg_written = 1'b1;
      side_d.reg_index   = rf_wr.idx;
      side_d.reg_value   = rf_wr.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 16'h0000;
      cc_q        <= CC_Z;
      start_pc_q  <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cc_q        <= cc_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        start_pc_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q     <= ir_d;
    side_q   <= side_d;
    ea_q     <= ea_d;
    ea_lsb_q <= ea_lsb_d;
    out_q    <= out_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.next_pc       = out_q.next_pc;
  assign rsp_o.cond_codes    = out_q.cond_codes;
  assign rsp_o.reg_written   = out_q.side.reg_written;
  assign rsp_o.reg_index     = out_q.side.reg_index;
  assign rsp_o.reg_value     = out_q.side.reg_value;
  assign rsp_o.store_kind    = out_q.side.store_kind;
  assign rsp_o.store_address = out_q.side.store_address;
  assign rsp_o.store_value   = out_q.side.store_value;
  assign rsp_o.halted        = out_q.halted;

  `LC3B_ASSERT_NOW(a_no_req_in_clear, clr_busy, !req_i.ready, "request taken during clear")
  `LC3B_ASSERT_NEXT(a_exec_fetches, req_fire && req_i.op == OP_EXEC && pc_q != 16'h0000,
    state_q == S_IR, "execute request did not fetch")
  `LC3B_ASSERT_NOW(a_rf_write_phase, rf_wr.we, state_q == S_EX || state_q == S_MEM,
    "register write outside execute")
  `LC3B_ASSERT_NOW(a_wb_fills_slot, state_q == S_WB && slot_free, out_valid_d,
    "result lost at write back")

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// lc3b instruction executor core testbench
// drives start pc writes, memory writes, restarts, single-step executes and unused request codes into the core,
// predicts every result from a shadow copy of memory, registers, pc and
// codes, and compares each result field by field under random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lc3b_pkg::*;

  localparam int MEM_WORDS  = 32768;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] word_address;
    logic [15:0] write_data;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lc3b_cfg_if cfg ();
  lc3b_req_if req ();
  lc3b_rsp_if rsp ();

  lc3b_instruction_executor_core #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow state of the core
  logic [15:0] shadow_mem [MEM_WORDS];
  logic [15:0] shadow_rf [8];
  logic [15:0] shadow_pc;
  logic [2:0]  shadow_cc;
  logic [15:0] shadow_start;

  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];

  int errors = 0;
  int cycles = 0;
  int sent_count = 0;
  int got_count = 0;
  int exec_count = 0;
  int store_count = 0;
  int cfg_count = 0;
  bit steady = 1'b0;
  bit req_took = 1'b0;
  bit cfg_took = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int halt_seen = 0;

  function automatic logic [2:0] flags_of(logic [15:0] v);
    if (v == 16'h0000) return CC_Z;
    return v[15] ? CC_N : CC_P;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic step_core(input cmd_t c, output rsp_t r);
    logic [15:0] pc, ir, inc, a, b, off6, base6, word6, nextpc, res, w;
    logic [3:0]  opc;
    logic [2:0]  dr;
    logic        wr;
    r = '0;
    wr = 1'b0;
    res = '0;
    dr = '0;
    if (c.op == OP_WRITE) begin
      shadow_mem[c.word_address] = c.write_data;
    end else if (c.op == OP_RESTART) begin
      shadow_pc = shadow_start;
      shadow_cc = CC_Z;
    end else if (c.op == OP_EXEC && shadow_pc != 16'h0000) begin
      pc = shadow_pc;
      ir = shadow_mem[pc[15:1]];
      inc = pc + 16'd2;
      opc = ir[15:12];
      dr = ir[11:9];
      a = shadow_rf[ir[8:6]];
      b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : shadow_rf[ir[2:0]];
      off6 = {{10{ir[5]}}, ir[5:0]};
      base6 = a + off6;
      word6 = a + (off6 << 1);
      nextpc = inc;
      exec_count++;
      case (opc)
        OPC_BR: begin
          if ((dr & shadow_cc) != 3'd0) nextpc = inc + ({{7{ir[8]}}, ir[8:0]} << 1);
        end
        OPC_ADD: begin res = a + b; wr = 1'b1; end
        OPC_AND: begin res = a & b; wr = 1'b1; end
        OPC_XOR: begin res = a ^ b; wr = 1'b1; end
        OPC_LDB: begin
          w = shadow_mem[base6[15:1]];
          res = base6[0] ? {{8{w[15]}}, w[15:8]} : {{8{w[7]}}, w[7:0]};
          wr = 1'b1;
        end
        OPC_STB: begin
          w = shadow_mem[base6[15:1]];
          if (base6[0]) w[15:8] = shadow_rf[dr][7:0];
          else w[7:0] = shadow_rf[dr][7:0];
          shadow_mem[base6[15:1]] = w;
          r.side.store_kind = SK_BYTE;
          r.side.store_address = base6;
          r.side.store_value = {8'h00, shadow_rf[dr][7:0]};
        end
        OPC_JSR: begin
          // base register is read before the link register is written
          nextpc = ir[11] ? inc + ({{5{ir[10]}}, ir[10:0]} << 1) : a;
          dr = REG_LINK;
          res = inc;
          wr = 1'b1;
        end
        OPC_LDW: begin res = shadow_mem[word6[15:1]]; wr = 1'b1; end
        OPC_STW: begin
          shadow_mem[word6[15:1]] = shadow_rf[dr];
          r.side.store_kind = SK_WORD;
          r.side.store_address = word6;
          r.side.store_value = shadow_rf[dr];
        end
        OPC_JMP: nextpc = a;
        OPC_SHF: begin
          if (!ir[4]) res = a << ir[3:0];
          else if (!ir[5]) res = a >> ir[3:0];
          else res = $signed(a) >>> ir[3:0];
          wr = 1'b1;
        end
        OPC_LEA: begin res = inc + ({{7{ir[8]}}, ir[8:0]} << 1); wr = 1'b1; end
        OPC_TRAP: begin
          nextpc = shadow_mem[{7'd0, ir[7:0]}];
          dr = REG_LINK;
          res = inc;
          wr = 1'b1;
        end
        default: nextpc = pc;
      endcase
      if (wr) begin
        shadow_rf[dr] = res;
        if (opc != OPC_JSR && opc != OPC_LEA && opc != OPC_TRAP) shadow_cc = flags_of(res);
      end
      if (r.side.store_kind != SK_NONE) store_count++;
      shadow_pc = nextpc;
    end
    r.next_pc = shadow_pc;
    r.cond_codes = shadow_cc;
    r.side.reg_written = wr;
    r.side.reg_index = wr ? dr : 3'd0;
    r.side.reg_value = wr ? res : 16'h0000;
    r.halted = (shadow_pc == 16'h0000);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h want %h", got_count, what, got, want);
  endtask

  // input side: acceptance, prediction and cycle limit
  always @(posedge clk_i) begin
    rsp_t r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end else begin
      req_took <= req.valid && req.ready;
      cfg_took <= cfg.valid && cfg.ready;
      if (cfg.valid && cfg.ready) shadow_start <= cfg.data;
      if (req.valid && req.ready) begin
        step_core(pending_cmds[0], r);
        void'(pending_cmds.pop_front());
        expected_rsps.push_back(r);
        sent_count <= sent_count + 1;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!(req.valid && !req_took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        req.valid <= 1'b1;
        req.op <= pending_cmds[0].op;
        req.word_address <= pending_cmds[0].word_address;
        req.write_data <= pending_cmds[0].write_data;
        gap_left <= steady ? 0 : pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off mid run
  always @(negedge clk_i) begin
    if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (steady) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= (pick_gap() == 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got_count <= got_count + 1;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result, next_pc", rsp.next_pc, 16'h0000);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.halted) halt_seen++;
        if (rsp.next_pc !== want.next_pc) report_mismatch("next_pc", rsp.next_pc, want.next_pc);
        if (rsp.cond_codes !== want.cond_codes)
          report_mismatch("cond_codes", rsp.cond_codes, want.cond_codes);
        if (rsp.reg_written !== want.side.reg_written)
          report_mismatch("reg_written", rsp.reg_written, want.side.reg_written);
        if (rsp.reg_index !== want.side.reg_index)
          report_mismatch("reg_index", rsp.reg_index, want.side.reg_index);
        if (rsp.reg_value !== want.side.reg_value)
          report_mismatch("reg_value", rsp.reg_value, want.side.reg_value);
        if (rsp.store_kind !== want.side.store_kind)
          report_mismatch("store_kind", rsp.store_kind, want.side.store_kind);
        if (rsp.store_address !== want.side.store_address)
          report_mismatch("store_address", rsp.store_address, want.side.store_address);
        if (rsp.store_value !== want.side.store_value)
          report_mismatch("store_value", rsp.store_value, want.side.store_value);
        if (rsp.halted !== want.halted) report_mismatch("halted", rsp.halted, want.halted);
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [14:0] wa, input logic [15:0] wd);
    cmd_t c;
    c.op = op;
    c.word_address = wa;
    c.write_data = wd;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_start_pc(input logic [15:0] v);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(negedge clk_i); while (!cfg_took);
    cfg.valid <= 1'b0;
    cfg_count++;
  endtask

  function automatic logic [15:0] rand_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    // keep jumps and subroutine calls from leaving the program too often
    if (ir[15:12] == OPC_JMP || ir[15:12] == OPC_JSR) begin
      if ($urandom_range(0, 2) != 0) ir[15:12] = OPC_ADD;
    end
    return ir;
  endfunction

  logic [15:0] directed_prog[] = '{
    16'h127F, 16'h947F, 16'h5641, 16'hD873, 16'hD853, 16'hD861, 16'hEA00,
    16'h3341, 16'h737F, 16'h2D41, 16'h6D40, 16'h0000, 16'h0E00, 16'hF001,
    16'h41C0
  };

  initial begin
    logic [14:0] base;
    logic [15:0] starts[7];
    int n;
    cfg.valid = 1'b0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.op = '0;
    req.word_address = '0;
    req.write_data = '0;
    rsp.ready = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    foreach (shadow_rf[i]) shadow_rf[i] = '0;
    shadow_pc = '0;
    shadow_cc = CC_Z;
    shadow_start = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // halted core, unused request code, memory extremes, restart to zero
    push_cmd(OP_EXEC, 15'd0, 16'h0000);
    push_cmd(OP_UNUSED, 15'h7FFF, 16'hFFFF);
    push_cmd(OP_WRITE, 15'h7FFF, 16'hFFFF);
    push_cmd(OP_WRITE, 15'h0001, 16'h3000);
    push_cmd(OP_RESTART, 15'd0, 16'h0000);
    push_cmd(OP_EXEC, 15'd0, 16'h0000);
    wait_idle();

    // top word: pc wraps to zero and halts
    write_start_pc(16'hFFFE);
    push_cmd(OP_WRITE, 15'h7FFF, 16'h1021);
    push_cmd(OP_RESTART, 15'd0, 16'h0000);
    push_cmd(OP_EXEC, 15'd0, 16'h0000);
    wait_idle();

    // most opcode families in one program, then the idle opcodes
    write_start_pc(16'h3000);
    foreach (directed_prog[i]) push_cmd(OP_WRITE, 15'(15'h1800 + i), directed_prog[i]);
    push_cmd(OP_RESTART, 15'd0, 16'h0000);
    repeat (directed_prog.size() + 1) push_cmd(OP_EXEC, 15'd0, 16'h0000);
    push_cmd(OP_WRITE, 15'h1800, 16'h8000);
    push_cmd(OP_WRITE, 15'h1801, 16'hA000);
    push_cmd(OP_WRITE, 15'h1802, 16'hB000);
    push_cmd(OP_RESTART, 15'd0, 16'h0000);
    push_cmd(OP_EXEC, 15'd0, 16'h0000);
    wait_idle();

    starts = '{16'h3000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'h0200};
    starts[3] = 16'($urandom);
    starts[4] = 16'($urandom) | 16'h0001;
    foreach (starts[p]) begin
      wait_idle();
      write_start_pc(starts[p]);
      steady = (p == 1);
      repeat (8) begin
        base = starts[p][15:1];
        n = $urandom_range(4, 10);
        for (int i = 0; i < n; i++) push_cmd(OP_WRITE, 15'(base + i), rand_instr());
        push_cmd(OP_WRITE, 15'($urandom), 16'($urandom));
        push_cmd(OP_WRITE, 15'($urandom_range(0, 255)), 16'($urandom));
        push_cmd(OP_RESTART, 15'($urandom), 16'($urandom));
        repeat ($urandom_range(6, 14)) push_cmd(OP_EXEC, 15'($urandom), 16'($urandom));
        if ($urandom_range(0, 4) == 0) push_cmd(2'($urandom), 15'($urandom), 16'($urandom));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("ran %0d requests, %0d executed, %0d stores, %0d halted results, %0d start pc writes",
             sent_count, exec_count, store_count, halt_seen, cfg_count);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_rsps.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
